FILE: sv/ise_pkg.sv
// ----------------------------------------------------------------------------
// ise_pkg
// Shared types and constants for the insertion sort engine.
// ----------------------------------------------------------------------------
package ise_pkg;

    localparam int MAX_ELEMENTS_DEF = 64;
    localparam int VALUE_W          = 32;
    localparam int POS_W            = 6;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value_res;
        logic [POS_W-1:0]          position;
        logic                      final_res;
        logic                      overflow;
    } result_t;

    typedef enum logic {
        ST_COLLECT,
        ST_DRAIN
    } ise_state_t;

    typedef struct packed {
        logic insert;
        logic drop;
        logic pop;
    } ise_cmd_t;

    typedef struct packed {
        logic full;
        logic last_pop;
        logic out_free;
    } ise_status_t;

endpackage

FILE: sv/ise_ctrl.sv
// ----------------------------------------------------------------------------
// ise_ctrl
// Collect/drain sequencer: accepts values until the set ends, then steps the
// datapath through the drain of the sorted row.
// ----------------------------------------------------------------------------
module ise_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  logic                item_last,
    output logic                item_ready,
    input  ise_pkg::ise_status_t status,
    output ise_pkg::ise_cmd_t    cmd
);

    ise_pkg::ise_state_t state_reg;
    ise_pkg::ise_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ise_pkg::ST_COLLECT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        item_ready = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ise_pkg::ST_COLLECT:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.insert = !status.full;
                    cmd.drop   = status.full;
                    if (item_last)
                    begin
                        state_next = ise_pkg::ST_DRAIN;
                    end
                end
            end
            ise_pkg::ST_DRAIN:
            begin
                cmd.pop = status.out_free;
                if (status.out_free && status.last_pop)
                begin
                    state_next = ise_pkg::ST_COLLECT;
                end
            end
            default:
            begin
                state_next = ise_pkg::ST_COLLECT;
            end
        endcase
    end

endmodule

FILE: sv/ise_datapath.sv
// ----------------------------------------------------------------------------
// ise_datapath
// Row of sorted cells with parallel compare-and-shift insertion, fill count,
// drop flag, and the output register fed from the bottom cell on drain.
// ----------------------------------------------------------------------------
module ise_datapath #(
    parameter int MAX_ELEMENTS = ise_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic signed [ise_pkg::VALUE_W-1:0] value,
    input  ise_pkg::ise_cmd_t                  cmd,
    output ise_pkg::ise_status_t               status,
    output logic                               result_valid,
    input  logic                               result_ready,
    output ise_pkg::result_t                   result
);

    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

    logic signed [ise_pkg::VALUE_W-1:0] cell_reg [MAX_ELEMENTS];
    logic [MAX_ELEMENTS-1:0]            gt;
    logic [MAX_ELEMENTS-1:0]            ins;
    logic [CNT_W-1:0]                   fill_reg;
    logic [CNT_W-1:0]                   fill_next;
    logic [CNT_W-1:0]                   pos_reg;
    logic [CNT_W-1:0]                   pos_next;
    logic                               dropped_reg;
    logic                               dropped_next;
    logic                               out_valid_reg;
    ise_pkg::result_t                   out_reg;

    assign status.full     = (fill_reg == CNT_W'(MAX_ELEMENTS));
    assign status.last_pop = (fill_reg == CNT_W'(1));
    assign status.out_free = !out_valid_reg || result_ready;

    genvar i;
    generate
        for (i = 0; i < MAX_ELEMENTS; i++)
        begin : g_cell
            logic signed [ise_pkg::VALUE_W-1:0] ins_src;
            logic signed [ise_pkg::VALUE_W-1:0] pop_src;

            assign gt[i]  = (CNT_W'(i) < fill_reg) && (cell_reg[i] > value);
            assign ins[i] = gt[i] || (fill_reg == CNT_W'(i));

            if (i == 0)
            begin : g_first
                assign ins_src = value;
            end
            else
            begin : g_rest
                assign ins_src = gt[i-1] ? cell_reg[i-1] : value;
            end

            if (i == MAX_ELEMENTS - 1)
            begin : g_top
                assign pop_src = cell_reg[i];
            end
            else
            begin : g_below
                assign pop_src = cell_reg[i+1];
            end

            always_ff @(posedge clk)
            begin
                if (cmd.insert && ins[i])
                begin
                    cell_reg[i] <= ins_src;
                end
                else if (cmd.pop)
                begin
                    cell_reg[i] <= pop_src;
                end
            end
        end
    endgenerate

    always_comb
    begin
        fill_next    = fill_reg;
        pos_next     = pos_reg;
        dropped_next = dropped_reg;
        if (cmd.insert)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        if (cmd.drop)
        begin
            dropped_next = 1'b1;
        end
        if (cmd.pop)
        begin
            fill_next = fill_reg - CNT_W'(1);
            if (status.last_pop)
            begin
                pos_next     = '0;
                dropped_next = 1'b0;
            end
            else
            begin
                pos_next = pos_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            pos_reg       <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg    <= fill_next;
            pos_reg     <= pos_next;
            dropped_reg <= dropped_next;
            if (cmd.pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pop)
        begin
            out_reg.value_res <= cell_reg[0];
            out_reg.position  <= ise_pkg::POS_W'(pos_reg);
            out_reg.final_res <= status.last_pop;
            out_reg.overflow  <= dropped_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(MAX_ELEMENTS))
        else $error("fill count beyond capacity");

    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> !cmd.insert && !cmd.drop)
        else $error("insert or drop during drain");

    a_drain_end: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop && status.last_pop |=> fill_reg == '0 && !dropped_reg && pos_reg == '0)
        else $error("store not emptied after run");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.insert |=> fill_reg == $past(fill_reg) + CNT_W'(1))
        else $error("fill count not advanced on insert");

endmodule

FILE: sv/insertion_sort_engine.sv
// ----------------------------------------------------------------------------
// insertion_sort_engine
// Streaming insertion sort of signed 32-bit values.
// ----------------------------------------------------------------------------
// Values are taken one per cycle and inserted into an ascending row of
// MAX_ELEMENTS cells in the cycle of their transfer; equal values keep arrival
// order. The transfer flagged last ends the set: input then stalls while the
// row drains from its bottom cell through the output register, one result per
// cycle when the consumer keeps ready high; the next value is taken only once
// the row has drained. Values arriving at a full row are dropped and every
// result of that run carries overflow.
module insertion_sort_engine #(
    parameter int MAX_ELEMENTS = ise_pkg::MAX_ELEMENTS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  ise_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output ise_pkg::result_t result
);

    ise_pkg::ise_cmd_t    cmd;
    ise_pkg::ise_status_t status;

    ise_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_last  (item.last),
        .item_ready (item_ready),
        .status     (status),
        .cmd        (cmd)
    );

    ise_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .value        (item.value),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the insertion sort engine.
// ----------------------------------------------------------------------------
// Sets of signed values are streamed into the engine. A scoreboard keeps its
// own sorted row and predicts every sorted run, including full rows and runs
// with dropped values. Each result transfer is checked field by field against
// the oldest prediction. Both handshake sides stall at random. One long
// consumer hold-off backs the engine up into its input. One quiet stretch
// runs with no stalls at all.
// ----------------------------------------------------------------------------
module tb;

    localparam int CAP         = ise_pkg::MAX_ELEMENTS_DEF;
    localparam int VALUE_W     = ise_pkg::VALUE_W;
    localparam int POS_W       = ise_pkg::POS_W;
    localparam int HOLD_OFF    = 400;
    localparam int STALL_MAX   = 2000;
    localparam int TOTAL_ITEMS = 180;

    class sort_scoreboard;
        logic signed [VALUE_W-1:0] row [CAP];
        int                        filled;
        bit                        dropped;
        ise_pkg::result_t          expected_results [$];
        int                        errors;
        int                        checked;
        int                        runs;
        int                        overflow_runs;

        function new();
            filled        = 0;
            dropped       = 1'b0;
            errors        = 0;
            checked       = 0;
            runs          = 0;
            overflow_runs = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void note_item(ise_pkg::item_t it);
            int               slot;
            ise_pkg::result_t r;
            if (filled < CAP)
            begin
                slot = filled;
                while (slot > 0 && row[slot-1] > it.value)
                begin
                    row[slot] = row[slot-1];
                    slot--;
                end
                row[slot] = it.value;
                filled++;
            end
            else
            begin
                dropped = 1'b1;
            end
            if (!it.last)
                return;
            for (int k = 0; k < filled; k++)
            begin
                r.value_res = row[k];
                r.position  = POS_W'(k);
                r.final_res = (k == filled - 1);
                r.overflow  = dropped;
                expected_results.push_back(r);
            end
            runs++;
            if (dropped)
                overflow_runs++;
            filled  = 0;
            dropped = 1'b0;
        endfunction

        function void check_result(ise_pkg::result_t got);
            ise_pkg::result_t want;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: value_res %0d position %0d",
                       got.value_res, got.position);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            checked++;
            if (got.value_res !== want.value_res)
            begin
                $error("value_res: expected %0d, actual %0d", want.value_res, got.value_res);
                errors++;
            end
            if (got.position !== want.position)
            begin
                $error("position: expected %0d, actual %0d", want.position, got.position);
                errors++;
            end
            if (got.final_res !== want.final_res)
            begin
                $error("final_res: expected %0b, actual %0b", want.final_res, got.final_res);
                errors++;
            end
            if (got.overflow !== want.overflow)
            begin
                $error("overflow: expected %0b, actual %0b", want.overflow, got.overflow);
                errors++;
            end
        endfunction
    endclass

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             item_valid   = 1'b0;
    logic             item_ready;
    ise_pkg::item_t   item         = '0;
    logic             result_valid;
    logic             result_ready = 1'b0;
    ise_pkg::result_t result;

    bit               no_stalls    = 1'b0;
    int               hold_reqs    = 0;
    int               holds_done   = 0;
    int               stall_cycles = 0;
    int               values_in    = 0;

    sort_scoreboard sb = new();

    insertion_sort_engine #(
        .MAX_ELEMENTS (CAP)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #5 clk = ~clk;

    // transfer monitor and stall watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && item_ready)
                sb.note_item(item);
            if (result_valid && result_ready)
                sb.check_result(result);
            if ((item_valid && item_ready) || (result_valid && result_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_MAX)
            begin
                $display("timeout: no transfer for %0d cycles", STALL_MAX);
                $display("FAIL");
                $finish;
            end
        end
    end

    // consumer
    always
    begin
        @(negedge clk);
        if (holds_done < hold_reqs)
        begin
            result_ready = 1'b0;
            repeat (HOLD_OFF) @(negedge clk);
            holds_done++;
        end
        result_ready = no_stalls || ($urandom_range(0, 99) >= 30);
    end

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 4))
            0:       return VALUE_W'(int'($urandom_range(0, 8)) - 4);
            1:       return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            2:       return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'($urandom_range(0, 3))};
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(input logic signed [VALUE_W-1:0] v, input logic l);
        if (!no_stalls && $urandom_range(0, 99) < 30)
        begin
            @(negedge clk);
            item_valid = 1'b0;
            repeat ($urandom_range(0, 3)) @(negedge clk);
        end
        @(negedge clk);
        item.value = v;
        item.last  = l;
        item_valid = 1'b1;
        do @(posedge clk); while (!item_ready);
        values_in++;
    endtask

    task automatic send_set(input int n);
        for (int i = 0; i < n; i++)
            send_item(pick_value(), i == n - 1);
    endtask

    task automatic drain_all();
        @(negedge clk);
        item_valid = 1'b0;
        while (sb.pending() != 0) @(negedge clk);
    endtask

    initial
    begin
        int start;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // single-element run at the negative extreme
        send_item(32'sh8000_0000, 1'b1);
        // extremes, duplicates and alternating bit patterns
        send_item(32'sh7FFF_FFFF, 1'b0);
        send_item(32'sh8000_0000, 1'b0);
        send_item(32'sh0000_0000, 1'b0);
        send_item(-32'sd1, 1'b0);
        send_item(32'sd1, 1'b0);
        send_item(32'sd7, 1'b0);
        send_item(32'sd7, 1'b0);
        send_item(-32'sd7, 1'b0);
        send_item(32'sh7FFF_FFFF, 1'b0);
        send_item(32'sh8000_0000, 1'b0);
        send_item(32'sh5555_5555, 1'b0);
        send_item(32'shAAAA_AAAA, 1'b0);
        send_item(32'sd3, 1'b1);
        // ascending then descending arrival
        for (int i = 0; i < 4; i++)
            send_item(VALUE_W'(i), 1'b0);
        send_item(32'sd4, 1'b1);
        for (int i = 5; i > 0; i--)
            send_item(VALUE_W'(i * 100), i == 1);

        start = values_in;
        while (values_in - start < 20)
            send_set($urandom_range(1, 12));

        // full row while the consumer holds off; the next set backs up behind it
        hold_reqs++;
        send_set(CAP);
        send_set($urandom_range(2, 6));

        // pause for the engine to empty, then overflow with no stalls anywhere
        drain_all();
        no_stalls = 1'b1;
        send_set(CAP + 3);
        drain_all();
        no_stalls = 1'b0;

        while (values_in < TOTAL_ITEMS)
            send_set($urandom_range(1, 12));

        drain_all();
        repeat (20) @(posedge clk);

        if (sb.pending() != 0)
        begin
            $error("%0d expected results never arrived", sb.pending());
            sb.errors++;
        end
        $display("%0d values in %0d runs (%0d with dropped values), %0d results checked",
                 values_in, sb.runs, sb.overflow_runs, sb.checked);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: sim.f
sv/ise_pkg.sv
sv/ise_ctrl.sv
sv/ise_datapath.sv
sv/insertion_sort_engine.sv
dv/tb.sv
